// ----- rtl/tgc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture classifier package
// Shared widths, gesture codes, frame and state types, and the dominant-axis
// decision function used by the classifier datapath.
// ----------------------------------------------------------------------------
package tgc_pkg;

    localparam int COORD_BITS   = 12;
    localparam int COUNT_BITS   = 4;
    localparam int THRESH_BITS  = 12;
    localparam int CMP_BITS     = (COORD_BITS > THRESH_BITS) ? COORD_BITS : THRESH_BITS;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(10);

    localparam logic [COUNT_BITS-1:0] COUNT_NONE   = COUNT_BITS'(0);
    localparam logic [COUNT_BITS-1:0] COUNT_SINGLE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_PAIR   = COUNT_BITS'(2);

    typedef logic [COORD_BITS-1:0]         coord_t;
    typedef logic signed [COORD_BITS:0]    delta_t;
    typedef logic [THRESH_BITS-1:0]        thresh_t;
    typedef logic [COUNT_BITS-1:0]         count_t;

    typedef enum logic [3:0] {
        G_NONE   = 4'd0,
        G_TOUCH  = 4'd1,
        G_RIGHT  = 4'd2,
        G_LEFT   = 4'd3,
        G_DOWN   = 4'd4,
        G_UP     = 4'd5,
        G_ZIN_X  = 4'd6,
        G_ZOUT_X = 4'd7,
        G_ZIN_Y  = 4'd8,
        G_ZOUT_Y = 4'd9
    } gesture_t;

    // One touch-controller frame.
    typedef struct packed {
        count_t point_count;
        coord_t first_x;
        coord_t first_y;
        coord_t second_x;
        coord_t second_y;
    } frame_t;

    // Tracking state: the previous frame and the gesture origin.
    typedef struct packed {
        frame_t last;
        coord_t start_x;
        coord_t start_y;
    } track_t;

    // Outcome of classifying one frame.
    typedef struct packed {
        gesture_t gesture;
        logic     origin_load;
        coord_t   start_x;
        coord_t   start_y;
    } decision_t;

    // Magnitude of a signed difference; every difference here stays within a coordinate.
    function automatic coord_t mag(input delta_t d);
        delta_t m;
        begin
            m = (d < 0) ? -d : d;
            return m[COORD_BITS-1:0];
        end
    endfunction

    // Picks the dominant axis (a tie goes to y) and maps its move to a code.
    function automatic gesture_t pick_axis(input delta_t dx, input delta_t dy,
                                           input thresh_t thr,
                                           input gesture_t xpos, input gesture_t xneg,
                                           input gesture_t ypos, input gesture_t yneg);
        coord_t ax;
        coord_t ay;
        begin
            ax = mag(dx);
            ay = mag(dy);
            if (ax > ay)
            begin
                if (CMP_BITS'(ax) < CMP_BITS'(thr))
                    return G_TOUCH;
                return (dx > 0) ? xpos : xneg;
            end
            if (CMP_BITS'(ay) < CMP_BITS'(thr))
                return G_TOUCH;
            return (dy > 0) ? ypos : yneg;
        end
    endfunction

endpackage

// ----- rtl/tgc_frame_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame channel
// Valid/ready channel that carries one touch-controller frame per word.
// ----------------------------------------------------------------------------
interface tgc_frame_if;
    import tgc_pkg::*;

    logic   valid;
    logic   ready;
    count_t point_count;
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;

    modport source (output valid, point_count, first_x, first_y, second_x, second_y,
                    input ready);
    modport sink (input valid, point_count, first_x, first_y, second_x, second_y,
                  output ready);
endinterface

// ----- rtl/tgc_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one gesture code and origin per word.
// ----------------------------------------------------------------------------
interface tgc_result_if;
    import tgc_pkg::*;

    logic       valid;
    logic       ready;
    logic [3:0] gesture;
    coord_t     start_x;
    coord_t     start_y;

    modport source (output valid, gesture, start_x, start_y, input ready);
    modport sink (input valid, gesture, start_x, start_y, output ready);
endinterface

// ----- rtl/tgc_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the inertia threshold register.
// ----------------------------------------------------------------------------
interface tgc_cfg_if;
    import tgc_pkg::*;

    logic    valid;
    logic    ready;
    thresh_t data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/tgc_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture classification datapath
// Compares one frame with the tracked previous frame and decides the
// gesture code and whether and where the gesture origin moves.
// ----------------------------------------------------------------------------
module tgc_classify (
    input  tgc_pkg::frame_t    frame_in,
    input  tgc_pkg::track_t    track,
    input  tgc_pkg::thresh_t   thresh,
    output tgc_pkg::decision_t decision
);
    import tgc_pkg::*;

    delta_t             move_x;
    delta_t             move_y;
    coord_t             span_x_cur;
    coord_t             span_x_prev;
    coord_t             span_y_cur;
    coord_t             span_y_prev;
    delta_t             zoom_x;
    delta_t             zoom_y;
    logic [COORD_BITS:0] sum_x;
    logic [COORD_BITS:0] sum_y;
    gesture_t           move_code;
    gesture_t           zoom_code;
    logic               count_changed;

    // Single-point move of the first point.
    assign move_x = $signed({1'b0, frame_in.first_x}) - $signed({1'b0, track.last.first_x});
    assign move_y = $signed({1'b0, frame_in.first_y}) - $signed({1'b0, track.last.first_y});

    // Spans of the point pair, now and in the previous frame.
    assign span_x_cur  = mag($signed({1'b0, frame_in.second_x}) - $signed({1'b0, frame_in.first_x}));
    assign span_y_cur  = mag($signed({1'b0, frame_in.second_y}) - $signed({1'b0, frame_in.first_y}));
    assign span_x_prev = mag($signed({1'b0, track.last.second_x})
                             - $signed({1'b0, track.last.first_x}));
    assign span_y_prev = mag($signed({1'b0, track.last.second_y})
                             - $signed({1'b0, track.last.first_y}));
    assign zoom_x = $signed({1'b0, span_x_cur}) - $signed({1'b0, span_x_prev});
    assign zoom_y = $signed({1'b0, span_y_cur}) - $signed({1'b0, span_y_prev});

    // Floored midpoint sums for a new two-point gesture.
    assign sum_x = {1'b0, frame_in.first_x} + {1'b0, frame_in.second_x};
    assign sum_y = {1'b0, frame_in.first_y} + {1'b0, frame_in.second_y};

    assign move_code = pick_axis(move_x, move_y, thresh, G_RIGHT, G_LEFT, G_DOWN, G_UP);
    assign zoom_code = pick_axis(zoom_x, zoom_y, thresh, G_ZIN_X, G_ZOUT_X, G_ZIN_Y, G_ZOUT_Y);
    assign count_changed = (frame_in.point_count != track.last.point_count);

    // Final selection by point count: an empty frame gives no gesture, and otherwise a count change takes priority.
    always_comb
    begin
        decision.gesture     = G_NONE;
        decision.origin_load = 1'b0;
        decision.start_x     = frame_in.first_x;
        decision.start_y     = frame_in.first_y;
        if (frame_in.point_count == COUNT_NONE)
        begin
            decision.gesture = G_NONE;
        end
        else if (count_changed)
        begin
            decision.gesture = G_TOUCH;
            case (frame_in.point_count)
                COUNT_SINGLE:
                begin
                    decision.origin_load = 1'b1;
                end
                COUNT_PAIR:
                begin
                    decision.origin_load = 1'b1;
                    decision.start_x     = sum_x[COORD_BITS:1];
                    decision.start_y     = sum_y[COORD_BITS:1];
                end
                default:
                begin
                    decision.origin_load = 1'b0;
                end
            endcase
        end
        else
        begin
            case (frame_in.point_count)
                COUNT_SINGLE: decision.gesture = move_code;
                COUNT_PAIR:   decision.gesture = zoom_code;
                default:      decision.gesture = G_NONE;
            endcase
        end
    end

endmodule

// ----- rtl/touch_gesture_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch gesture classifier
// Classifies each touch-controller frame against the previous one and
// reports a gesture code with the current gesture origin.
//
//   Channel  Dir  Word
//   frame    in   point_count, first_x, first_y, second_x, second_y
//   result   out  gesture, start_x, start_y
//   cfg      in   data (inertia threshold, 12 bits)
//
// A frame is registered at the input, classified from the input register and
// written to the result register when that register is free. One frame per
// cycle is sustained while the result is not stalled; the classify stage is
// a single combinational stage between the two registers.
// Reset clears the tracked frame and origin to zero and the threshold to 10.
// A stalled result holds the classify stage; the input keeps taking words
// until both registers are full.
// ----------------------------------------------------------------------------
module touch_gesture_classifier (
    input  logic         clk,
    input  logic         rst_n,
    tgc_frame_if.sink    frame,
    tgc_result_if.source result,
    tgc_cfg_if.sink      cfg
);
    import tgc_pkg::*;

    logic      in_valid_reg;
    frame_t    in_frame_reg;
    logic      res_valid_reg;
    gesture_t  res_gesture_reg;
    coord_t    res_start_x_reg;
    coord_t    res_start_y_reg;
    track_t    track_reg;
    track_t    track_next;
    thresh_t   thresh_reg;
    decision_t decision;
    logic      advance;
    frame_t    frame_word;

    // Stage hand-off: the input register moves on when the result register frees up.
    assign advance     = in_valid_reg && (!res_valid_reg || result.ready);
    assign frame.ready = !in_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    assign frame_word.point_count = frame.point_count;
    assign frame_word.first_x     = frame.first_x;
    assign frame_word.first_y     = frame.first_y;
    assign frame_word.second_x    = frame.second_x;
    assign frame_word.second_y    = frame.second_y;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= THRESH_RESET;
        else if (cfg.valid && cfg.ready)
            thresh_reg <= cfg.data;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (frame.ready)
            in_valid_reg <= frame.valid;
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
            in_frame_reg <= frame_word;
    end

    tgc_classify u_classify (
        .frame_in (in_frame_reg),
        .track    (track_reg),
        .thresh   (thresh_reg),
        .decision (decision)
    );

    // Next tracking state: every frame becomes the previous frame.
    always_comb
    begin
        track_next      = track_reg;
        track_next.last = in_frame_reg;
        if (decision.origin_load)
        begin
            track_next.start_x = decision.start_x;
            track_next.start_y = decision.start_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            track_reg <= '0;
        else if (advance)
            track_reg <= track_next;
    end

    // Result register; the origin reads as zero when there is no gesture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_gesture_reg <= decision.gesture;
            res_start_x_reg <= (decision.gesture == G_NONE) ? '0 : track_next.start_x;
            res_start_y_reg <= (decision.gesture == G_NONE) ? '0 : track_next.start_y;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.gesture = res_gesture_reg;
    assign result.start_x = res_start_x_reg;
    assign result.start_y = res_start_y_reg;

    // A word with no gesture never carries an origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_gesture_reg == G_NONE) |->
            (res_start_x_reg == '0 && res_start_y_reg == '0))
        else $error("origin not cleared on a result without a gesture");

    // A frame with no points always classifies as no gesture.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_frame_reg.point_count == COUNT_NONE) |=>
            (res_valid_reg && res_gesture_reg == G_NONE))
        else $error("empty frame did not give an empty gesture");

    // The input may only take a word into a full register when that word moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready && in_valid_reg) |-> advance)
        else $error("input register overwritten while stalled");

    // A frame that moves on becomes the tracked previous frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (track_reg.last == $past(in_frame_reg)))
        else $error("previous frame not tracked");

endmodule
